/* rtl/interval_map_range_assign_core_assert.svh */
// assertion macros shared by the checker
`ifndef INTERVAL_MAP_RANGE_ASSIGN_CORE_ASSERT_SVH
`define INTERVAL_MAP_RANGE_ASSIGN_CORE_ASSERT_SVH

// same-cycle implication
`define IMB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("imb check failed");

// next-cycle implication
`define IMB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("imb check failed");

`endif

/* rtl/imb_pkg.sv */
// types, constants and helpers for the interval map core
package imb_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int KEY_WIDTH   = 16;
    localparam int VALUE_WIDTH = 8;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 3);

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam logic REQ_ASSIGN = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic {S_IDLE, S_SCAN} t_state;
    typedef enum logic [1:0] {PH_LOW, PH_MID, PH_HIGH} t_phase;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] val;
    } t_entry;

    typedef struct packed {
        logic            en;
        logic [ADDR_W:0] addr;
        t_entry          data;
    } t_wr_port;

    function automatic logic [KEY_WIDTH-1:0] order_key(input logic [KEY_WIDTH-1:0] k);
        order_key = {~k[KEY_WIDTH-1], k[KEY_WIDTH-2:0]};
    endfunction
endpackage

/* rtl/imb_store.sv */
// two-bank breakpoint table memory, one write and one registered read per cycle
module imb_store import imb_pkg::*; (
    input  logic            i_clk,
    input  t_wr_port        i_wr,
    input  logic [ADDR_W:0] i_rd_addr,
    output t_entry          o_rd_data
);
    t_entry r_mem [2*TABLE_DEPTH];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;
endmodule

/* rtl/imb_seq.sv */
// request sequencer with the shared key comparator
module imb_seq import imb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic                   i_req_type,
    input  logic [KEY_WIDTH-1:0]   i_key_begin,
    input  logic [KEY_WIDTH-1:0]   i_key_end,
    input  logic [VALUE_WIDTH-1:0] i_assign_value,
    input  logic [KEY_WIDTH-1:0]   i_lookup_key,
    input  logic                   i_cfg_valid,
    input  logic [VALUE_WIDTH-1:0] i_cfg_data,
    input  t_entry                 i_rd_data,
    output logic [ADDR_W:0]        o_rd_addr,
    output t_wr_port               o_wr,
    output logic                   busy,
    output logic                   o_result_strobe,
    output logic [VALUE_WIDTH-1:0] o_read_value,
    output t_status                o_status
);
    t_state                 r_state, n_state;
    t_phase                 r_phase, n_phase;
    logic                   r_type, n_type;
    logic [KEY_WIDTH-1:0]   r_kb, n_kb, r_ke, n_ke, r_lk, n_lk;
    logic [VALUE_WIDTH-1:0] r_val, n_val, r_before, n_before, r_at_end, n_at_end;
    logic [VALUE_WIDTH-1:0] r_init, n_init;
    logic [CNT_W-1:0]       r_idx, n_idx, r_n, n_n, r_count, n_count;
    logic                   r_bank, n_bank;
    logic                   r_strobe, n_strobe;
    logic [VALUE_WIDTH-1:0] r_rv, n_rv;
    t_status                r_st, n_st;
    logic [KEY_WIDTH-1:0]   cmp_b;
    logic                   cmp_lt, cmp_le, have, room;
    logic [KEY_WIDTH-1:0]   kb_in, ke_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_LOW;
            r_idx    <= '0;
            r_n      <= '0;
            r_count  <= '0;
            r_bank   <= 1'b0;
            r_strobe <= 1'b0;
            r_init   <= '0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_n      <= n_n;
            r_count  <= n_count;
            r_bank   <= n_bank;
            r_strobe <= n_strobe;
            r_init   <= n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_kb     <= n_kb;
        r_ke     <= n_ke;
        r_lk     <= n_lk;
        r_val    <= n_val;
        r_before <= n_before;
        r_at_end <= n_at_end;
        r_rv     <= n_rv;
        r_st     <= n_st;
    end

    // shared comparator
    always_comb begin
        if (r_type == REQ_LOOKUP) begin
            cmp_b = r_lk;
        end else if (r_phase == PH_LOW) begin
            cmp_b = r_kb;
        end else begin
            cmp_b = r_ke;
        end
        cmp_lt = i_rd_data.key < cmp_b;
        cmp_le = cmp_lt || (i_rd_data.key == cmp_b);
    end

    assign have  = r_idx < r_count;
    assign room  = r_n < CNT_W'(TABLE_DEPTH);
    assign kb_in = order_key(i_key_begin);
    assign ke_in = order_key(i_key_end);

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_type   = r_type;
        n_kb     = r_kb;
        n_ke     = r_ke;
        n_lk     = r_lk;
        n_val    = r_val;
        n_before = r_before;
        n_at_end = r_at_end;
        n_idx    = r_idx;
        n_n      = r_n;
        n_count  = r_count;
        n_bank   = r_bank;
        n_strobe = 1'b0;
        n_rv     = r_rv;
        n_st     = r_st;
        n_init   = r_init;
        o_wr.en   = 1'b0;
        o_wr.addr = {~r_bank, r_n[ADDR_W-1:0]};
        o_wr.data = i_rd_data;
        if (i_cfg_valid) begin
            n_init = i_cfg_data;
        end
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (start) begin
                    n_type   = i_req_type;
                    n_kb     = kb_in;
                    n_ke     = ke_in;
                    n_lk     = order_key(i_lookup_key);
                    n_val    = i_assign_value;
                    n_before = r_init;
                    n_at_end = r_init;
                    n_n      = '0;
                    n_phase  = PH_LOW;
                    if (i_req_type == REQ_ASSIGN && !(kb_in < ke_in)) begin
                        n_strobe = 1'b1;
                        n_rv     = '0;
                        n_st     = ST_EMPTY;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_type == REQ_LOOKUP) begin
                    if (have && cmp_le) begin
                        n_at_end = i_rd_data.val;
                        n_idx    = r_idx + CNT_W'(1);
                    end else begin
                        n_strobe = 1'b1;
                        n_rv     = r_at_end;
                        n_st     = ST_DONE;
                        n_state  = S_IDLE;
                        n_idx    = '0;
                    end
                end else begin
                    case (r_phase)
                        PH_LOW: begin
                            if (have && cmp_lt) begin
                                o_wr.en  = room;
                                n_n      = r_n + CNT_W'(1);
                                n_before = i_rd_data.val;
                                n_at_end = i_rd_data.val;
                                n_idx    = r_idx + CNT_W'(1);
                            end else begin
                                if (r_val != r_before) begin
                                    o_wr.en   = room;
                                    o_wr.data = '{key: r_kb, val: r_val};
                                    n_n       = r_n + CNT_W'(1);
                                end
                                n_phase = PH_MID;
                            end
                        end
                        PH_MID: begin
                            if (have && cmp_le) begin
                                n_at_end = i_rd_data.val;
                                n_idx    = r_idx + CNT_W'(1);
                            end else begin
                                if (r_at_end != r_val) begin
                                    o_wr.en   = room;
                                    o_wr.data = '{key: r_ke, val: r_at_end};
                                    n_n       = r_n + CNT_W'(1);
                                end
                                n_phase = PH_HIGH;
                            end
                        end
                        PH_HIGH: begin
                            if (have) begin
                                o_wr.en = room;
                                n_n     = r_n + CNT_W'(1);
                                n_idx   = r_idx + CNT_W'(1);
                            end else begin
                                n_strobe = 1'b1;
                                n_rv     = '0;
                                n_state  = S_IDLE;
                                n_idx    = '0;
                                if (r_n > CNT_W'(TABLE_DEPTH)) begin
                                    n_st = ST_FULL;
                                end else begin
                                    n_st    = ST_DONE;
                                    n_bank  = ~r_bank;
                                    n_count = r_n;
                                end
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rd_addr       = {n_bank, n_idx[ADDR_W-1:0]};
    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_read_value    = r_rv;
    assign o_status        = r_st;
endmodule

/* rtl/interval_map_range_assign_core.sv */
// top level of the interval map range assignment core
//
// channel   | direction | handshake
// request   | in        | start high while busy low
// result    | out       | o_result_strobe, one cycle
// config    | in        | i_cfg_valid and o_cfg_ready
//
// a lookup scans the breakpoints at or below the key, then answers
// an assign walks the breakpoints below, inside and above the range,
// one breakpoint per cycle through the single table read port
// an empty range answers in the cycle after its transfer
// reset clears the breakpoint count and initial_value, no clearing pass
// results cannot be stalled, busy stays high until the strobe cycle
module interval_map_range_assign_core import imb_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic signed [KEY_WIDTH-1:0]   i_key_begin,
    input  logic signed [KEY_WIDTH-1:0]   i_key_end,
    input  logic [VALUE_WIDTH-1:0]        i_assign_value,
    input  logic signed [KEY_WIDTH-1:0]   i_lookup_key,
    output logic                          o_result_strobe,
    output logic [VALUE_WIDTH-1:0]        o_read_value,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [VALUE_WIDTH-1:0]        i_cfg_data
);
    t_wr_port        wr;
    logic [ADDR_W:0] rd_addr;
    t_entry          rd_data;

    assign o_cfg_ready = 1'b1;

    imb_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    imb_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_req_type      (i_req_type),
        .i_key_begin     (i_key_begin),
        .i_key_end       (i_key_end),
        .i_assign_value  (i_assign_value),
        .i_lookup_key    (i_lookup_key),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_rd_data       (rd_data),
        .o_rd_addr       (rd_addr),
        .o_wr            (wr),
        .busy            (busy),
        .o_result_strobe (o_result_strobe),
        .o_read_value    (o_read_value),
        .o_status        (o_status)
    );
endmodule

/* rtl/imb_checker.sv */
// port-level checker for the interval map core, bound to the top level
`include "interval_map_range_assign_core_assert.svh"

module imb_checker import imb_pkg::*; (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_req_type,
    input logic signed [KEY_WIDTH-1:0] i_key_begin,
    input logic signed [KEY_WIDTH-1:0] i_key_end,
    input logic [VALUE_WIDTH-1:0]      i_assign_value,
    input logic signed [KEY_WIDTH-1:0] i_lookup_key,
    input logic                        o_result_strobe,
    input logic [VALUE_WIDTH-1:0]      o_read_value,
    input logic [1:0]                  o_status,
    input logic                        i_cfg_valid,
    input logic                        o_cfg_ready,
    input logic [VALUE_WIDTH-1:0]      i_cfg_data
);
    `IMB_ASSERT_IMP(a_strobe_not_busy, i_clk, i_rst_n, o_result_strobe, !busy)
    `IMB_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_result_strobe,
        o_status == ST_DONE || o_status == ST_EMPTY || o_status == ST_FULL)
    `IMB_ASSERT_IMP(a_reject_zero, i_clk, i_rst_n,
        o_result_strobe && o_status != ST_DONE, o_read_value == '0)
    `IMB_ASSERT_NXT(a_empty_range, i_clk, i_rst_n,
        start && !busy && i_req_type == REQ_ASSIGN && !(i_key_begin < i_key_end),
        o_result_strobe && o_status == ST_EMPTY)
    `IMB_ASSERT_NXT(a_lookup_busy, i_clk, i_rst_n,
        start && !busy && i_req_type == REQ_LOOKUP, busy && !o_result_strobe)
endmodule

bind interval_map_range_assign_core imb_checker u_imb_checker (.*);
